// ===== hw/rtl/frame_rate_window_meter_top_macros.svh =====
// Assertion helpers used by the meter's back end.
`ifndef FRAME_RATE_WINDOW_METER_TOP_MACROS_SVH
`define FRAME_RATE_WINDOW_METER_TOP_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define FRWM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("frwm assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define FRWM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("frwm assertion failed");

`endif

// ===== hw/rtl/frwm_pkg.sv =====
package frwm_pkg;

  localparam int unsigned StampW   = 64;
  localparam int unsigned TicksW   = 32;
  localparam int unsigned RateW    = 48;
  localparam int unsigned FracW    = 16;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 32;

  localparam logic [TicksW-1:0] TicksMax      = {TicksW{1'b1}};
  localparam logic [RateW-1:0]  RateMax       = {RateW{1'b1}};
  localparam logic [TicksW-1:0] TickRateReset = 32'd1000000000;

  // Register index, taken from paddr[2].
  localparam logic RegTickRate = 1'b0;

  // One frame length moving from the front end to the queue or the back end.
  typedef struct packed {
    logic              valid;
    logic [TicksW-1:0] ticks;
  } frwm_tick_t;

endpackage

// ===== hw/rtl/frwm_front.sv =====
module frwm_front import frwm_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [StampW-1:0] s_axis_tdata,   // [63:0] timestamp
  input  logic              q_ready_i,
  output frwm_tick_t        push_o
);

  logic              started_q, started_d;
  logic [StampW-1:0] last_q, last_d;
  logic [StampW-1:0] diff;
  logic              accept;

  assign s_axis_tready = q_ready_i;
  assign accept        = s_axis_tvalid & q_ready_i;

  always_comb begin
    diff      = s_axis_tdata - last_q;
    started_d = started_q | accept;
    last_d    = accept ? s_axis_tdata : last_q;
    push_o.valid = accept;
    if (!started_q) begin
      push_o.ticks = '0;
    end else if (|diff[StampW-1:TicksW]) begin
      push_o.ticks = TicksMax;
    end else begin
      push_o.ticks = diff[TicksW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      last_q    <= '0;
    end else begin
      started_q <= started_d;
      last_q    <= last_d;
    end
  end

endmodule

// ===== hw/rtl/frwm_queue.sv =====
module frwm_queue import frwm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  frwm_tick_t push_i,
  output logic       ready_o,
  output frwm_tick_t head_o,
  input  logic       pop_i
);

  logic [TicksW-1:0] slot_q [2];
  logic              wr_q, wr_d;
  logic              rd_q, rd_d;
  logic [1:0]        cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign ready_o      = (cnt_q != 2'd2);
  assign do_push      = push_i.valid & ready_o;
  assign do_pop       = pop_i & (cnt_q != 2'd0);
  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.ticks = slot_q[rd_q];

  always_comb begin
    wr_d  = do_push ? ~wr_q : wr_q;
    rd_d  = do_pop ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= push_i.ticks;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

// ===== hw/rtl/frwm_back.sv =====
`include "frame_rate_window_meter_top_macros.svh"

module frwm_back import frwm_pkg::*; #(
  parameter int unsigned WINDOW = 200
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  frwm_tick_t                head_i,
  output logic                      pop_o,
  input  logic [TicksW-1:0]         tick_rate_i,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  output logic [TicksW+RateW-1:0]   m_axis_tdata,  // [31:0] frame_ticks, [79:32] rate_q16
  output logic [1:0]                m_axis_tuser   // [0] rate_refreshed, [1] zero_window
);

  localparam int unsigned SlotW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned FillW = $clog2(WINDOW + 1);
  localparam int unsigned SumW  = TicksW + FillW;
  localparam int unsigned ProdW = FillW + TicksW;
  localparam int unsigned NumW  = ProdW + FracW;
  localparam int unsigned CntW  = $clog2(NumW);
  localparam logic [FillW-1:0] FillFull = FillW'(WINDOW);
  localparam logic [SlotW-1:0] SlotLast = SlotW'(WINDOW - 1);
  localparam logic [CntW-1:0]  CntLast  = CntW'(NumW - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_UPD, S_MUL, S_DIV, S_DONE
  } state_e;

  state_e            state_q, state_d;
  logic [TicksW-1:0] ring_mem [WINDOW];
  logic [TicksW-1:0] rd_q;
  logic [TicksW-1:0] ticks_q, ticks_d;
  logic [SlotW-1:0]  slot_q, slot_d;
  logic [FillW-1:0]  fill_q, fill_d;
  logic [SumW-1:0]   sum_q, sum_d;
  logic [TicksW:0]   accum_q, accum_d;
  logic              refr_q, refr_d;
  logic              zero_q, zero_d;
  logic [NumW-1:0]   dv_q, dv_d;
  logic [SumW-1:0]   rem_q, rem_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic              ovld_q, ovld_d;
  logic [TicksW-1:0] oticks_q, oticks_d;
  logic [RateW-1:0]  orate_q, orate_d;
  logic              orefr_q, orefr_d;
  logic              ozero_q, ozero_d;

  logic [TicksW-1:0] old_ticks;
  logic [TicksW:0]   accum_sum;
  logic [ProdW-1:0]  prod;
  logic [SumW:0]     trial, trial_sub;
  logic              ge;
  logic              mem_we;

  assign pop_o  = (state_q == S_IDLE) & head_i.valid;
  assign mem_we = (state_q == S_UPD);

  always_comb begin
    state_d  = state_q;
    ticks_d  = ticks_q;
    slot_d   = slot_q;
    fill_d   = fill_q;
    sum_d    = sum_q;
    accum_d  = accum_q;
    refr_d   = refr_q;
    zero_d   = zero_q;
    dv_d     = dv_q;
    rem_d    = rem_q;
    cnt_d    = cnt_q;
    ovld_d   = ovld_q & ~m_axis_tready;
    oticks_d = oticks_q;
    orate_d  = orate_q;
    orefr_d  = orefr_q;
    ozero_d  = ozero_q;

    // Until the ring has wrapped, the slot about to be overwritten was never written.
    old_ticks = (fill_q == FillFull) ? rd_q : '0;
    accum_sum = accum_q + {1'b0, ticks_q};
    prod      = {{TicksW{1'b0}}, fill_q} * {{FillW{1'b0}}, tick_rate_i};
    trial     = {rem_q, dv_q[NumW-1]};
    trial_sub = trial - {1'b0, sum_q};
    ge        = (trial >= {1'b0, sum_q});

    unique case (state_q)
      S_IDLE: begin
        if (head_i.valid) begin
          ticks_d = head_i.ticks;
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        sum_d  = sum_q - SumW'(old_ticks) + SumW'(ticks_q);
        zero_d = (sum_d == '0);
        if (fill_q != FillFull) begin
          fill_d = fill_q + 1'b1;
        end
        slot_d = (slot_q == SlotLast) ? '0 : slot_q + 1'b1;
        refr_d = (accum_sum > {1'b0, tick_rate_i});
        accum_d = refr_d ? '0 : accum_sum;
        state_d = S_MUL;
      end
      S_MUL: begin
        dv_d    = {prod, {FracW{1'b0}}};
        rem_d   = '0;
        cnt_d   = '0;
        state_d = zero_q ? S_DONE : S_DIV;
      end
      S_DIV: begin
        rem_d = ge ? trial_sub[SumW-1:0] : trial[SumW-1:0];
        dv_d  = {dv_q[NumW-2:0], ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!ovld_q || m_axis_tready) begin
          ovld_d   = 1'b1;
          oticks_d = ticks_q;
          orefr_d  = refr_q;
          ozero_d  = zero_q;
          if (zero_q || (|dv_q[NumW-1:RateW])) begin
            orate_d = RateMax;
          end else begin
            orate_d = dv_q[RateW-1:0];
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ring_mem[slot_q] <= ticks_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= ring_mem[slot_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      ticks_q  <= '0;
      slot_q   <= '0;
      fill_q   <= '0;
      sum_q    <= '0;
      accum_q  <= '0;
      refr_q   <= 1'b0;
      zero_q   <= 1'b0;
      dv_q     <= '0;
      rem_q    <= '0;
      cnt_q    <= '0;
      ovld_q   <= 1'b0;
      oticks_q <= '0;
      orate_q  <= '0;
      orefr_q  <= 1'b0;
      ozero_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      ticks_q  <= ticks_d;
      slot_q   <= slot_d;
      fill_q   <= fill_d;
      sum_q    <= sum_d;
      accum_q  <= accum_d;
      refr_q   <= refr_d;
      zero_q   <= zero_d;
      dv_q     <= dv_d;
      rem_q    <= rem_d;
      cnt_q    <= cnt_d;
      ovld_q   <= ovld_d;
      oticks_q <= oticks_d;
      orate_q  <= orate_d;
      orefr_q  <= orefr_d;
      ozero_q  <= ozero_d;
    end
  end

  assign m_axis_tvalid = ovld_q;
  assign m_axis_tdata  = {orate_q, oticks_q};
  assign m_axis_tuser  = {ozero_q, orefr_q};

  `FRWM_ASSERT_IMP(a_fill_bound, clk_i, rst_ni, 1'b1, fill_q <= FillFull)
  `FRWM_ASSERT_IMP(a_slot_tracks_fill, clk_i, rst_ni, fill_q != FillFull, FillW'(slot_q) == fill_q)
  `FRWM_ASSERT_IMP(a_div_nonzero, clk_i, rst_ni, state_q == S_DIV, sum_q != '0)
  `FRWM_ASSERT_NXT(a_upd_to_mul, clk_i, rst_ni, state_q == S_UPD, state_q == S_MUL)

endmodule

// ===== hw/rtl/frame_rate_window_meter_top.sv =====
// Path: an accepted timestamp request passes the queue, the ring update, the multiply,
//   a restoring divide of NumW = 56 bits at WINDOW 200, and the output register.
// Flow: the back end takes one request at a time, its divider giving one bit a cycle;
//   an empty window skips the divide. A two-entry queue takes requests meanwhile.
// Reset: rst_ni asynchronous, active low; clears the window, sum, fill count and
//   timestamp history, and restores tick_rate to 1000000000. No clearing pass.
module frame_rate_window_meter_top import frwm_pkg::*; #(
  parameter int unsigned WINDOW = 200
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // timestamp request stream
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  input  logic [StampW-1:0]       s_axis_tdata,   // [63:0] timestamp
  // result stream
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  output logic [TicksW+RateW-1:0] m_axis_tdata,   // [31:0] frame_ticks, [79:32] rate_q16
  output logic [1:0]              m_axis_tuser,   // [0] rate_refreshed, [1] zero_window
  // configuration port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [CfgAddrW-1:0]     paddr,
  input  logic [CfgDataW-1:0]     pwdata,
  output logic [CfgDataW-1:0]     prdata,
  output logic                    pready
);

  frwm_tick_t        push;
  frwm_tick_t        head;
  logic              q_ready;
  logic              pop;
  logic [TicksW-1:0] tick_rate_q, tick_rate_d;
  logic              cfg_wr;

  // Configuration: one register, tick_rate, at byte address 0. The port never
  // stalls; writes to any other word are dropped and read back as zero.
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    tick_rate_d = tick_rate_q;
    if (cfg_wr && (paddr[2] == RegTickRate)) begin
      tick_rate_d = pwdata;
    end
    prdata = (paddr[2] == RegTickRate) ? tick_rate_q : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_rate_q <= TickRateReset;
    end else begin
      tick_rate_q <= tick_rate_d;
    end
  end

  // Front end: take each timestamp request, turn it into a saturated frame
  // length against the previous stamp, and hand it to the queue.
  frwm_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .q_ready_i     (q_ready),
    .push_o        (push)
  );

  // Short queue: decouple the front end from the divider so either may stall.
  frwm_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .ready_o (q_ready),
    .head_o  (head),
    .pop_i   (pop)
  );

  // Back end: update the frame ring, running sum, fill count and one-second
  // accumulator, then divide fill_count * tick_rate * 2^16 by the nonzero window sum.
  // The result waits in an output register, so new requests keep queueing.
  frwm_back #(
    .WINDOW (WINDOW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .pop_o         (pop),
    .tick_rate_i   (tick_rate_q),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

// ===== test/frame_rate_window_meter_top_tb.sv =====
module frame_rate_window_meter_top_tb import frwm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Window        = 200;
  localparam int unsigned PhaseItems    = 280;
  // Margin after the last result before a register write; every request yields a result.
  localparam int unsigned SettleCycles  = 8;
  // Quiet cycles after the final result, well beyond the block's latency.
  localparam int unsigned EndCycles     = 100;
  // Slowest request: block processing plus the longest source gap and sink stall.
  localparam int unsigned WatchdogLimit = 3000;

  localparam logic [CfgAddrW-1:0] TickRateAddr  = {RegTickRate, 2'b00};
  localparam logic [CfgAddrW-1:0] UnusedRegAddr = 3'd4;

  // Expected result of one timestamp request.
  typedef struct packed {
    logic [TicksW-1:0] ticks;
    logic [RateW-1:0]  rate;
    logic              refreshed;
    logic              zero_win;
  } meter_result_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    s_axis_tvalid;
  logic                    s_axis_tready;
  logic [StampW-1:0]       s_axis_tdata;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready;
  logic [TicksW+RateW-1:0] m_axis_tdata;
  logic [1:0]              m_axis_tuser;
  logic                    psel;
  logic                    penable;
  logic                    pwrite;
  logic [CfgAddrW-1:0]     paddr;
  logic [CfgDataW-1:0]     pwdata;
  logic [CfgDataW-1:0]     prdata;
  logic                    pready;

  frame_rate_window_meter_top #(
    .WINDOW(Window)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // Meter state as the block should hold it, plus the programmed tick rate.
  logic [TicksW-1:0] tick_rate_cfg = TickRateReset;
  logic              stamp_seen    = 1'b0;
  logic [StampW-1:0] prev_stamp    = '0;
  logic [TicksW-1:0] frame_lengths [Window] = '{default: '0};
  int unsigned       ring_pos      = 0;
  int unsigned       frames_held   = 0;
  logic [39:0]       window_total  = '0;
  logic [63:0]       second_total  = '0;

  meter_result_t pending_rates [$];
  int unsigned   mismatch_count = 0;
  int unsigned   quiet_cycles   = 0;
  int            source_calm    = 0;
  int            sink_calm      = 0;
  int            sink_hold      = 0;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Print one line per mismatch and count it.
  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Pick an idle length: mostly none or short, now and then long, with calm stretches.
  function automatic int pick_pause(inout int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      calm_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 4);
    if (r < 97) return $urandom_range(5, 30);
    return $urandom_range(60, 150);
  endfunction

  // Advance the meter state by one timestamp and work out its result.
  function automatic meter_result_t measure_frame(input logic [StampW-1:0] stamp);
    meter_result_t res;
    logic [63:0]   diff;
    logic [63:0]   span;
    logic [63:0]   quotient;
    span = '0;
    if (stamp_seen) begin
      // wrap modulo 2^64, then clip to 32 bits
      diff = stamp - prev_stamp;
      span = (diff > 64'(TicksMax)) ? 64'(TicksMax) : diff;
    end
    stamp_seen   = 1'b1;
    prev_stamp   = stamp;
    window_total = window_total - 40'(frame_lengths[ring_pos]) + 40'(span);
    frame_lengths[ring_pos] = span[TicksW-1:0];
    second_total = second_total + span;
    if (frames_held < Window) frames_held++;
    ring_pos = (ring_pos == Window - 1) ? 0 : ring_pos + 1;

    res.ticks    = span[TicksW-1:0];
    res.zero_win = (window_total == '0);
    if (res.zero_win) begin
      res.rate = RateMax;
    end else begin
      // truncating divide, then clip to 48 bits
      quotient = ((64'(frames_held) * 64'(tick_rate_cfg)) << FracW) / 64'(window_total);
      res.rate = (quotient > 64'(RateMax)) ? RateMax : quotient[RateW-1:0];
    end
    // the pulse fires once accumulated time passes one second, then restarts
    res.refreshed = (second_total > 64'(tick_rate_cfg));
    if (res.refreshed) second_total = '0;
    return res;
  endfunction

  // Offer one timestamp request after a random gap; predict its result on acceptance.
  task automatic send_stamp(input logic [StampW-1:0] stamp);
    int gap;
    gap = pick_pause(source_calm);
    @(negedge clk_i);
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = stamp;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_rates.push_back(measure_frame(stamp));
  endtask

  // Drop valid and hold until every expected result is back.
  task automatic drain_results();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pending_rates.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // One APB transfer: setup cycle, then access cycle completed when pready is high.
  task automatic apb_access(input logic write, input logic [CfgAddrW-1:0] addr,
                            input logic [CfgDataW-1:0] wdata,
                            output logic [CfgDataW-1:0] rdata);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = write;
    paddr   = addr;
    pwdata  = wdata;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    // only the tick rate register exists; other addresses are ignored
    if (write && addr == TickRateAddr) tick_rate_cfg = wdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic check_tick_rate();
    logic [CfgDataW-1:0] rd;
    apb_access(1'b0, TickRateAddr, '0, rd);
    if (rd !== tick_rate_cfg)
      report_mismatch($sformatf("tick_rate read %0h, expected %0h", rd, tick_rate_cfg));
  endtask

  task automatic set_tick_rate(input logic [CfgDataW-1:0] value);
    logic [CfgDataW-1:0] rd;
    apb_access(1'b1, TickRateAddr, value, rd);
    check_tick_rate();
  endtask

  // Empty window after reset, then saturation of the rate with a one-tick sum.
  task automatic test_window_start();
    check_tick_rate();
    send_stamp(64'd0);
    drain_results();
    set_tick_rate(32'hFFFF_FFFF);
    send_stamp(64'd0);
    send_stamp(64'd1);
    send_stamp(64'd1);
    drain_results();
  endtask

  // Wrap, backwards steps and the 32-bit clipping boundary of the frame length.
  task automatic test_timestamp_extremes();
    send_stamp(64'hFFFF_FFFF_FFFF_FFFF);
    send_stamp(64'd0);
    send_stamp(64'h0000_0000_FFFF_FFFF);
    send_stamp(64'h0000_0001_0000_0000);
    send_stamp(64'hAAAA_AAAA_5555_5555);
    send_stamp(64'h5555_5555_AAAA_AAAA);
    send_stamp(64'h5555_5556_AAAA_AAAA);
    drain_results();
  endtask

  // Smallest tick rate, then a zero tick rate that forces a zero rate.
  task automatic test_tick_rate_extremes();
    set_tick_rate(32'd1);
    send_stamp(prev_stamp + 64'd1);
    send_stamp(prev_stamp + 64'd1);
    send_stamp(prev_stamp);
    send_stamp(prev_stamp + 64'd2);
    drain_results();
    set_tick_rate(32'd0);
    send_stamp(prev_stamp);
    send_stamp(prev_stamp + 64'd3);
    drain_results();
  endtask

  // Writes to an address with no register must leave the tick rate alone.
  task automatic test_unused_register();
    logic [CfgDataW-1:0] rd;
    apb_access(1'b1, UnusedRegAddr, 32'hFFFF_FFFF, rd);
    check_tick_rate();
    set_tick_rate(TickRateReset);
    apb_access(1'b1, UnusedRegAddr, 32'd0, rd);
    check_tick_rate();
    send_stamp(prev_stamp + 64'd16_666_667);
    send_stamp(prev_stamp + 64'd16_666_666);
    drain_results();
  endtask

  // Phases at several tick rates, each long enough to wrap the window.
  task automatic test_random_frames();
    logic [TicksW-1:0] phase_rates [7];
    logic [63:0]       base;
    logic [63:0]       delta;
    logic [StampW-1:0] stamp;
    int                r;
    phase_rates[0] = TickRateReset;
    phase_rates[1] = 32'hFFFF_FFFF;
    phase_rates[2] = 32'd1;
    phase_rates[3] = $urandom;
    phase_rates[4] = 32'd60 * $urandom_range(1, 1000);
    phase_rates[5] = 32'd0;
    phase_rates[6] = $urandom_range(1000, 100000);
    foreach (phase_rates[p]) begin
      drain_results();
      set_tick_rate(phase_rates[p]);
      repeat (PhaseItems) begin
        r = $urandom_range(0, 99);
        if (tick_rate_cfg == '0) base = 64'($urandom_range(0, 5000));
        else base = 64'(tick_rate_cfg) / 64'($urandom_range(20, 240));
        if (r < 70) begin
          // plausible frame lengths around 20..240 frames per second
          delta = base + 64'($urandom_range(0, 1000));
          stamp = prev_stamp + delta;
        end else if (r < 80) begin
          stamp = prev_stamp + 64'($urandom_range(0, 3));
        end else if (r < 86) begin
          stamp = prev_stamp;
        end else if (r < 90) begin
          stamp = prev_stamp + ({$urandom, $urandom} | 64'h1_0000_0000);
        end else if (r < 92) begin
          stamp = prev_stamp + 64'(TicksMax) + 64'($urandom_range(0, 1));
        end else if (r < 96) begin
          stamp = prev_stamp - 64'($urandom_range(1, 1000));
        end else begin
          stamp = {$urandom, $urandom};
        end
        send_stamp(stamp);
      end
    end
    drain_results();
  endtask

  // Result sink: random back-pressure with calm stretches.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (sink_hold > 0) begin
        m_axis_tready = 1'b0;
        sink_hold--;
      end else begin
        m_axis_tready = 1'b1;
        sink_hold = pick_pause(sink_calm);
      end
    end
  end

  // Compare each accepted result with the oldest prediction, field by field.
  always @(posedge clk_i) begin : check_results
    meter_result_t got;
    meter_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.ticks     = m_axis_tdata[TicksW-1:0];
      got.rate      = m_axis_tdata[TicksW +: RateW];
      got.refreshed = m_axis_tuser[0];
      got.zero_win  = m_axis_tuser[1];
      if (pending_rates.size() == 0) begin
        report_mismatch($sformatf("result with no request pending: ticks %0h rate %0h",
                                  got.ticks, got.rate));
      end else begin
        want = pending_rates.pop_front();
        if (got.ticks !== want.ticks)
          report_mismatch($sformatf("frame_ticks %0h, expected %0h", got.ticks, want.ticks));
        if (got.rate !== want.rate)
          report_mismatch($sformatf("rate_q16 %0h, expected %0h", got.rate, want.rate));
        if (got.refreshed !== want.refreshed)
          report_mismatch($sformatf("rate_refreshed %0b, expected %0b",
                                    got.refreshed, want.refreshed));
        if (got.zero_win !== want.zero_win)
          report_mismatch($sformatf("zero_window %0b, expected %0b",
                                    got.zero_win, want.zero_win));
      end
    end
  end

  // End the run if neither stream moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WatchdogLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    rst_ni        = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_window_start();
    test_timestamp_extremes();
    test_tick_rate_extremes();
    test_unused_register();
    test_random_frames();

    // hold a while longer to catch any stray result
    repeat (EndCycles) @(posedge clk_i);
    if (mismatch_count == 0 && pending_rates.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/frwm_pkg.sv
hw/rtl/frwm_front.sv
hw/rtl/frwm_queue.sv
hw/rtl/frwm_back.sv
hw/rtl/frame_rate_window_meter_top.sv
test/frame_rate_window_meter_top_tb.sv
